FILE: hw/rtl/sts_pkg.sv
package sts_pkg;

    localparam int REG_WORDS = 64;
    localparam int ADDR_W    = $clog2(REG_WORDS);

    localparam logic [31:0] TRN_MASK    = 32'hffb3_0f90;
    localparam logic [31:0] TRN_VALUE   = 32'hf3b2_0080;
    localparam logic [31:0] THUMB_MASK  = 32'hef00_0000;
    localparam logic [31:0] SIMD_BASE   = 32'hf200_0000;
    localparam logic [31:0] LOW24_MASK  = 32'h00ff_ffff;
    localparam logic [15:0] HALF_MASK   = 16'hffff;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_EXEC  = 2'd2;

    typedef struct packed {
        logic [1:0]        kind;
        logic              thumb_mode;
        logic [31:0]       instr_word;
        logic [ADDR_W-1:0] word_index;
        logic [31:0]       word_data;
    } t_item;

    typedef struct packed {
        logic        handled;
        logic [31:0] read_data;
    } t_result;

    // controller -> datapath
    typedef struct packed {
        logic       load;        // latch base word of the transposed register
        logic       rd;          // read port enable
        logic       wr;          // write port enable
        logic       sel_item;    // address/data from the live item, else base + idx
        logic [1:0] idx;
        logic       res_handled;
        logic       res_is_read;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic hit;   // quirk on and the live instruction qualifies
        logic quad;  // Q form: four words
    } t_status;

    // Thumb-2 Advanced SIMD to ARM form; a bad Thumb prefix gives zero
    function automatic logic [31:0] to_simd_form(input logic thumb, input logic [31:0] w);
        logic [31:0] res;
        res = w;
        if (thumb) begin
            if ((w & THUMB_MASK) != THUMB_MASK) begin
                res = '0;
            end else begin
                res = SIMD_BASE | {7'd0, w[28], 24'd0} | (w & LOW24_MASK);
            end
        end
        return res;
    endfunction

endpackage

FILE: hw/rtl/sts_ctrl.sv
module sts_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  logic [1:0]       i_kind,
    input  sts_pkg::t_status i_status,
    output logic             busy,
    output logic             o_valid,
    output sts_pkg::t_cmd    o_cmd
);
    import sts_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_XREAD,
        S_XWRITE
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_idx, n_idx;
    logic [1:0] r_last, n_last;
    logic       r_valid, n_valid;
    logic       r_handled, n_handled;
    logic       r_is_read, n_is_read;
    logic       accept;

    assign accept = start && (r_state == S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_last    = r_last;
        n_valid   = 1'b0;
        n_handled = 1'b0;
        n_is_read = 1'b0;
        o_cmd     = '0;
        o_cmd.idx = r_idx;
        // result flags ride along with the command group
        o_cmd.res_handled = r_handled;
        o_cmd.res_is_read = r_is_read;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.sel_item = 1'b1;
                    unique case (i_kind)
                        KIND_WRITE: begin
                            o_cmd.wr = 1'b1;
                            n_valid  = 1'b1;
                        end
                        KIND_READ: begin
                            o_cmd.rd  = 1'b1;
                            n_valid   = 1'b1;
                            n_is_read = 1'b1;
                        end
                        KIND_EXEC: begin
                            if (i_status.hit) begin
                                o_cmd.load = 1'b1;
                                n_idx      = 2'd0;
                                n_last     = i_status.quad ? 2'd3 : 2'd1;
                                n_state    = S_XREAD;
                            end else begin
                                n_valid = 1'b1;
                            end
                        end
                        default: begin
                            n_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_XREAD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_XWRITE;
            end
            S_XWRITE: begin
                o_cmd.wr = 1'b1;
                if (r_idx == r_last) begin
                    n_valid   = 1'b1;
                    n_handled = 1'b1;
                    n_state   = S_IDLE;
                end else begin
                    n_idx   = r_idx + 2'd1;
                    n_state = S_XREAD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_idx     <= '0;
            r_last    <= '0;
            r_valid   <= 1'b0;
            r_handled <= 1'b0;
            r_is_read <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_last    <= n_last;
            r_valid   <= n_valid;
            r_handled <= n_handled;
            r_is_read <= n_is_read;
        end
    end

    assign busy = (r_state != S_IDLE);
    assign o_valid = r_valid;

endmodule

FILE: hw/rtl/sts_datapath.sv
module sts_datapath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_wdata,
    input  sts_pkg::t_item   i_item,
    input  sts_pkg::t_cmd    i_cmd,
    input  logic             i_res_handled,
    input  logic             i_res_is_read,
    output sts_pkg::t_status o_status,
    output sts_pkg::t_result o_result
);
    import sts_pkg::*;

    logic [31:0]          r_mem [REG_WORDS];
    logic [REG_WORDS-1:0] r_wvalid;
    logic [31:0]          r_rdata;
    logic [ADDR_W-1:0]    r_base;
    logic                 r_quirk;

    logic [31:0]       dec;
    logic [1:0]        size;
    logic              q;
    logic [4:0]        dst, src;
    logic [ADDR_W-1:0] first;
    logic [ADDR_W:0]   span_end;
    logic [ADDR_W-1:0] addr;
    logic [31:0]       wdata;

    // decode of the live instruction
    always_comb begin
        dec      = to_simd_form(i_item.thumb_mode, i_item.instr_word);
        size     = dec[19:18];
        q        = dec[6];
        dst      = {dec[22], dec[15:12]};
        src      = {dec[5], dec[3:0]};
        first    = {dst, 1'b0};
        span_end = {1'b0, first} + (q ? (ADDR_W+1)'(4) : (ADDR_W+1)'(2));
        o_status.quad = q;
        o_status.hit  = r_quirk
                     && ((dec & TRN_MASK) == TRN_VALUE)
                     && (size == 2'd1)
                     && (dst == src)
                     && !(q && dst[0])
                     && (span_end <= (ADDR_W+1)'(REG_WORDS));
    end

    assign addr  = i_cmd.sel_item ? i_item.word_index : r_base + ADDR_W'(i_cmd.idx);
    assign wdata = i_cmd.sel_item ? i_item.word_data
                                  : {r_rdata[15:0] & HALF_MASK, r_rdata[15:0] & HALF_MASK};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wvalid <= '0;
            r_quirk  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_quirk <= i_cfg_wdata;
            end
            if (i_cmd.wr) begin
                r_wvalid[addr] <= 1'b1;
            end
        end
    end

    // register file storage, unwritten words read as zero
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_mem[addr] <= wdata;
        end
        if (i_cmd.rd) begin
            r_rdata <= r_wvalid[addr] ? r_mem[addr] : 32'd0;
        end
        if (i_cmd.load) begin
            r_base <= first;
        end
    end

    assign o_result.handled   = i_res_handled;
    assign o_result.read_data = i_res_is_read ? r_rdata : 32'd0;

endmodule

FILE: hw/rtl/simd_transpose_self_quirk.sv
// SIMD self-transpose quirk unit with a 64-word x 32-bit register file.
//
// Input channel: an item (i_item: kind, thumb_mode, instr_word, word_index,
// word_data) is taken on a rising edge with start high and busy low.
// Output channel: every item gives one word on o_result, shown for exactly
// one cycle with o_valid high. The receiver cannot stall it.
// Config: i_cfg_we/i_cfg_wdata write quirk_profile_enable (resets to 0);
// write it only while the unit is idle.
//
// Behaviour by item kind:
//   write, read, unused kind, non-qualifying execute: result in the cycle after
//   accept, busy stays low, so one item per cycle.
//   qualifying execute: the single-port read/write of the register file is
//   stepped over each word (S_XREAD, then S_XWRITE), two words for a D and
//   four for a Q register; busy is high meanwhile and the next item can be
//   taken on the edge that ends the result cycle.
//
// Reset (synchronous, active low) clears the controller and a per-word
// written flag, so the whole file reads as zero at once; no clearing pass.
module simd_transpose_self_quirk (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  sts_pkg::t_item   i_item,
    input  logic             i_cfg_we,
    input  logic             i_cfg_wdata,
    output logic             o_valid,
    output sts_pkg::t_result o_result
);
    import sts_pkg::*;

    t_cmd    cmd;
    t_status status;

    sts_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_kind   (i_item.kind),
        .i_status (status),
        .busy     (busy),
        .o_valid  (o_valid),
        .o_cmd    (cmd)
    );

    sts_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_item        (i_item),
        .i_cmd         (cmd),
        .i_res_handled (cmd.res_handled),
        .i_res_is_read (cmd.res_is_read),
        .o_status      (status),
        .o_result      (o_result)
    );

    // a handled result only ends a busy sequence
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.handled |-> $past(busy))
        else $error("handled result without a busy sequence");

    // read data only on read results
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_result.read_data != 32'd0) |-> !o_result.handled)
        else $error("read data on an execute result");

    // non-execute items answer in the next cycle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_item.kind != KIND_EXEC) |=> o_valid)
        else $error("missing one-cycle result");

endmodule

FILE: tb/sv/simd_transpose_self_quirk_tb.sv
`timescale 1ns / 1ps

module simd_transpose_self_quirk_tb;
    import sts_pkg::*;

    // unused item kind: must change nothing and answer all zeros
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    // element size field value for 16-bit lanes
    localparam logic [1:0] SIZE_HALF   = 2'd1;

    localparam int SETTLE_CYCLES = 12;      // outlasts the longest busy stretch, a Q-register execute
    localparam int CYCLE_LIMIT   = 200000;  // watchdog limit on the whole run

    logic    i_clk       = 1'b0;
    logic    i_rst_n     = 1'b0;
    logic    start       = 1'b0;
    logic    busy;
    t_item   i_item      = '0;
    logic    i_cfg_we    = 1'b0;
    logic    i_cfg_wdata = 1'b0;
    logic    o_valid;
    t_result o_result;

    simd_transpose_self_quirk uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .o_valid    (o_valid),
        .o_result   (o_result)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Shadow copy of the block: register file and the quirk enable.
    logic [31:0] shadow_regs [REG_WORDS];
    logic        quirk_on = 1'b0;

    t_item   pending_words[$];   // items waiting for the driver
    t_result expected_words[$];  // predicted result words, oldest first
    t_item   live_word;          // item currently on i_item
    logic    no_gaps = 1'b0;     // suppresses random sender idling
    int      bad_words = 0;
    int      cycles = 0;

    initial begin
        for (int k = 0; k < REG_WORDS; k++) shadow_regs[k] = '0;
    end

    // Thumb-2 prefix check and rewrite to the ARM SIMD form; bad prefix gives zero.
    function automatic logic [31:0] arm_form(logic thumb, logic [31:0] w);
        if (!thumb) return w;
        if (w[31:29] != 3'b111 || w[27:24] != 4'hf) return '0;
        return {7'b1111_001, w[28], w[23:0]};
    endfunction

    // Applies one accepted item to the shadow state and returns its result word.
    function automatic t_result emulate_item(t_item it);
        t_result     r;
        logic [31:0] w;
        logic [4:0]  dst;
        logic [4:0]  src;
        logic        quad;
        int          base;
        int          n;
        logic [15:0] lo;
        r = '0;
        case (it.kind)
            KIND_WRITE: shadow_regs[it.word_index] = it.word_data;
            KIND_READ:  r.read_data = shadow_regs[it.word_index];
            KIND_EXEC: begin
                w    = arm_form(it.thumb_mode, it.instr_word);
                dst  = {w[22], w[15:12]};
                src  = {w[5], w[3:0]};
                quad = w[6];
                base = int'(dst) * 2;
                n    = quad ? 4 : 2;
                if (quirk_on && (w & TRN_MASK) == TRN_VALUE && w[19:18] == SIZE_HALF
                        && dst == src && !(quad && dst[0]) && base + n <= REG_WORDS) begin
                    for (int k = 0; k < n; k++) begin
                        lo = shadow_regs[base + k][15:0];
                        shadow_regs[base + k] = {lo, lo};
                    end
                    r.handled = 1'b1;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Transpose encoding in ARM form from its fields.
    function automatic logic [31:0] trn_word(logic [4:0] dst, logic quad, logic [1:0] sz,
                                             logic [4:0] src);
        logic [31:0] w;
        w = TRN_VALUE;
        w[22]    = dst[4];
        w[15:12] = dst[3:0];
        w[19:18] = sz;
        w[6]     = quad;
        w[5]     = src[4];
        w[3:0]   = src[3:0];
        return w;
    endfunction

    // ARM SIMD form back to its Thumb-2 encoding.
    function automatic logic [31:0] thumb_of(logic [31:0] a);
        return {3'b111, a[24], 4'hf, a[23:0]};
    endfunction

    function automatic t_item mk_item(logic [1:0] kind, logic thumb, logic [31:0] instr,
                                      logic [ADDR_W-1:0] idx, logic [31:0] data);
        t_item it;
        it.kind       = kind;
        it.thumb_mode = thumb;
        it.instr_word = instr;
        it.word_index = idx;
        it.word_data  = data;
        return it;
    endfunction

    // Random item. Executes are mostly well-formed self-transposes with random
    // registers, some with one field broken; the rest are raw noise words.
    function automatic t_item random_item();
        t_item      it;
        int         pick;
        logic [4:0] dst;
        logic [4:0] src;
        logic       quad;
        logic [1:0] sz;
        it.kind       = KIND_UNUSED;
        it.thumb_mode = 1'($urandom_range(0, 1));
        it.instr_word = $urandom();
        it.word_index = ADDR_W'($urandom_range(0, REG_WORDS - 1));
        it.word_data  = $urandom();
        pick = $urandom_range(0, 99);
        if (pick < 28) begin
            it.kind = KIND_WRITE;
        end else if (pick < 56) begin
            it.kind = KIND_READ;
        end else if (pick < 95) begin
            it.kind = KIND_EXEC;
            if ($urandom_range(0, 99) < 70) begin
                dst  = 5'($urandom_range(0, 31));
                quad = 1'($urandom_range(0, 1));
                if (quad) dst[0] = 1'b0;
                sz  = SIZE_HALF;
                src = dst;
                case ($urandom_range(0, 9))
                    0: sz = 2'($urandom_range(0, 3));
                    1: src = 5'($urandom_range(0, 31));
                    2: begin
                        quad   = 1'b1;
                        dst[0] = 1'b1;
                        src    = dst;
                    end
                    default: ;
                endcase
                it.instr_word = trn_word(dst, quad, sz, src);
                if (it.thumb_mode) it.instr_word = thumb_of(it.instr_word);
            end else if ($urandom_range(0, 1)) begin
                // noise with a valid Thumb prefix so the rewrite path sees it
                it.instr_word[31:24] = it.instr_word[31:24] | 8'hef;
            end
        end
        return it;
    endfunction

    // Driver: one word in flight on i_item; taken on an edge with start high
    // and busy low, predicted right there. start gets one assignment per edge.
    always @(posedge i_clk) begin
        logic taken;
        logic gap;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            taken = start && !busy;
            if (taken) expected_words.push_back(emulate_item(live_word));
            if (!start || taken) begin
                gap = !no_gaps && ($urandom_range(0, 99) < 13);
                if (pending_words.size() != 0 && !gap) begin
                    live_word = pending_words.pop_front();
                    i_item <= live_word;
                    start  <= 1'b1;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: every strobed result word is checked against the oldest prediction.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid) begin
            if (expected_words.size() == 0) begin
                $error("result word with none expected: handled=%0b read_data=%08h",
                       o_result.handled, o_result.read_data);
                bad_words++;
            end else begin
                want = expected_words.pop_front();
                if (o_result.handled !== want.handled) begin
                    $error("handled: expected %0b, got %0b", want.handled, o_result.handled);
                    bad_words++;
                end
                if (o_result.read_data !== want.read_data) begin
                    $error("read_data: expected %08h, got %08h",
                           want.read_data, o_result.read_data);
                    bad_words++;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL simd_transpose_self_quirk");
            $finish;
        end
    end

    // Sender holds off until every queued word went in and came back, then
    // lets the block settle.
    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending_words.size() != 0 || start || expected_words.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Only called while drained.
    task automatic write_quirk(logic v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        quirk_on = v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic feed_random(int n);
        for (int k = 0; k < n; k++) begin
            pending_words.push_back(random_item());
            if (k % 250 == 249) wait_drained();
        end
        wait_drained();
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // quirk off after reset: file extremes, unused kind, a valid transpose ignored
        pending_words.push_back(mk_item(KIND_WRITE, 1'b0, '0, 6'd0, 32'hffff_ffff));
        pending_words.push_back(mk_item(KIND_WRITE, 1'b0, '0, 6'd63, 32'h1234_5678));
        pending_words.push_back(mk_item(KIND_WRITE, 1'b1, '1, 6'd1, 32'ha5a5_5a5a));
        pending_words.push_back(mk_item(KIND_READ, 1'b0, '0, 6'd0, '0));
        pending_words.push_back(mk_item(KIND_READ, 1'b1, '1, 6'd63, '1));
        pending_words.push_back(mk_item(KIND_UNUSED, 1'b1, '1, 6'd63, '1));
        pending_words.push_back(mk_item(KIND_EXEC, 1'b0, trn_word(5'd0, 1'b0, SIZE_HALF, 5'd0),
                                        6'd0, '0));
        wait_drained();

        write_quirk(1'b1);
        // D0 in ARM form, then check both words
        pending_words.push_back(mk_item(KIND_EXEC, 1'b0, trn_word(5'd0, 1'b0, SIZE_HALF, 5'd0),
                                        6'd5, 32'hdead_beef));
        pending_words.push_back(mk_item(KIND_READ, 1'b0, '0, 6'd0, '0));
        pending_words.push_back(mk_item(KIND_READ, 1'b0, '0, 6'd1, '0));
        // top Q register in Thumb form, covers the last four words
        pending_words.push_back(mk_item(KIND_WRITE, 1'b0, '0, 6'd61, 32'h0bad_f00d));
        pending_words.push_back(mk_item(KIND_EXEC, 1'b1,
                                        thumb_of(trn_word(5'd30, 1'b1, SIZE_HALF, 5'd30)),
                                        '0, '0));
        pending_words.push_back(mk_item(KIND_READ, 1'b0, '0, 6'd61, '0));
        pending_words.push_back(mk_item(KIND_READ, 1'b0, '0, 6'd63, '0));
        // odd Q register, other sizes, unequal registers: all unhandled
        pending_words.push_back(mk_item(KIND_EXEC, 1'b0, trn_word(5'd3, 1'b1, SIZE_HALF, 5'd3),
                                        '0, '0));
        pending_words.push_back(mk_item(KIND_EXEC, 1'b0, trn_word(5'd4, 1'b0, 2'd0, 5'd4),
                                        '0, '0));
        pending_words.push_back(mk_item(KIND_EXEC, 1'b1,
                                        thumb_of(trn_word(5'd4, 1'b0, 2'd2, 5'd4)), '0, '0));
        pending_words.push_back(mk_item(KIND_EXEC, 1'b0, trn_word(5'd7, 1'b0, SIZE_HALF, 5'd8),
                                        '0, '0));
        // Thumb words without the prefix decode as zero
        pending_words.push_back(mk_item(KIND_EXEC, 1'b1, 32'h7fff_ffff, '0, '0));
        pending_words.push_back(mk_item(KIND_EXEC, 1'b1, 32'hf3b2_0080, '0, '0));
        // highest D register, with word_index and data that must be ignored
        pending_words.push_back(mk_item(KIND_EXEC, 1'b0, trn_word(5'd31, 1'b0, SIZE_HALF,
                                        5'd31), 6'd63, '1));
        pending_words.push_back(mk_item(KIND_EXEC, 1'b0, '0, '0, '0));
        pending_words.push_back(mk_item(KIND_EXEC, 1'b0, '1, '1, '1));
        pending_words.push_back(mk_item(KIND_WRITE, 1'b0, '0, 6'd62, '0));
        pending_words.push_back(mk_item(KIND_READ, 1'b0, '0, 6'd62, '1));
        wait_drained();

        feed_random(700);

        write_quirk(1'b0);
        feed_random(300);

        // long stretch without sender gaps
        write_quirk(1'b1);
        no_gaps = 1'b1;
        feed_random(400);
        no_gaps = 1'b0;
        feed_random(300);

        if (bad_words == 0) begin
            $display("PASS simd_transpose_self_quirk");
        end else begin
            $display("FAIL simd_transpose_self_quirk");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/sts_pkg.sv
hw/rtl/sts_ctrl.sv
hw/rtl/sts_datapath.sv
hw/rtl/simd_transpose_self_quirk.sv
tb/sv/simd_transpose_self_quirk_tb.sv
